FILE: rtl/tdcm_pkg.sv
// Shared types and constants of the TDC hit time and channel mapper.
package tdcm_pkg;

  localparam logic [2:0] MODE_MAP  = 3'd0;
  localparam logic [2:0] MODE_REF  = 3'd1;
  localparam logic [2:0] MODE_SYNC = 3'd2;
  localparam logic [2:0] MODE_HIT  = 3'd3;
  localparam logic [2:0] MODE_END  = 3'd4;

  typedef struct packed {
    logic [31:0] serial;
    logic [4:0]  slot;
    logic [6:0]  channel;
    logic [1:0]  plane;
    logic [7:0]  strip;
    logic [7:0]  side;
  } map_entry_t;

  typedef struct packed {
    logic        used;
    logic        lead_vld;
    logic        trail_vld;
    map_entry_t  entry;
    logic [47:0] lead_time;
    logic [47:0] trail_time;
  } map_cell_t;

  typedef struct packed {
    logic        load;
    logic        shift;
    logic        wr;
    logic        wr_lead;
    logic [47:0] wr_time;
  } cell_ctrl_t;

endpackage

FILE: rtl/tdcm_map_cell.sv
// One map cell: a channel map entry with its leading and trailing hit store.
module tdcm_map_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdcm_pkg::cell_ctrl_t  ctrl_i,
  input  logic                  sel_i,
  input  tdcm_pkg::map_entry_t  entry_i,
  input  tdcm_pkg::map_cell_t   shift_data_i,
  input  logic [31:0]           key_serial_i,
  input  logic [4:0]            key_slot_i,
  input  logic [6:0]            key_channel_i,
  output logic                  match_o,
  output tdcm_pkg::map_cell_t   data_o
);

  tdcm_pkg::map_cell_t cell_q, cell_d;

  assign match_o = cell_q.used && cell_q.entry.serial == key_serial_i &&
                   cell_q.entry.slot == key_slot_i && cell_q.entry.channel == key_channel_i;
  assign data_o  = cell_q;

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.shift) begin
      cell_d = shift_data_i;
    end else if (ctrl_i.load && sel_i) begin
      cell_d.used      = 1'b1;
      cell_d.lead_vld  = 1'b0;
      cell_d.trail_vld = 1'b0;
      cell_d.entry     = entry_i;
    end else if (ctrl_i.wr && sel_i) begin
      if (ctrl_i.wr_lead) begin
        cell_d.lead_vld  = 1'b1;
        cell_d.lead_time = ctrl_i.wr_time;
      end else begin
        cell_d.trail_vld  = 1'b1;
        cell_d.trail_time = ctrl_i.wr_time;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

endmodule

FILE: rtl/tdcm_sync_cell.sv
// One sync cell: serial and nanoseconds of a stored sync record.
module tdcm_sync_cell (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        used_i,
  input  logic [31:0] serial_i,
  input  logic [29:0] ns_i,
  input  logic [31:0] key_serial_i,
  input  logic [29:0] ns_in_i,
  output logic [29:0] ns_o
);

  logic [31:0] serial_q;
  logic [29:0] ns_q;

  // last match wins: a matching cell overrides the value from below
  assign ns_o = (used_i && serial_q == key_serial_i) ? ns_q : ns_in_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      serial_q <= serial_i;
      ns_q     <= ns_i;
    end
  end

endmodule

FILE: rtl/tdc_hit_time_channel_mapper_top.sv
// Top level of the TDC hit time and channel mapper.
// Usage: present a request on the item ports with start high; it is taken
// when busy is low. Mode 0 appends a map entry, mode 1 takes a reference
// hit, mode 2 a sync record, mode 3 a data hit, mode 4 ends the event.
// Modes 0, 1, 2 and 5 to 7 run one exec state, mode 3 adds a write state:
// the exec state looks up the sync cells, the write state matches the
// map cells, forms the corrected time and writes it into the first match.
// Mode 4 rotates the ring of MAP_DEPTH map cells once, one cell a cycle,
// examining the cell at the head; a found hit is held until the next one
// is found, and the last one leaves after the rotation with last_o high.
// Busy stays high through the exec, rotation and flush states. Each
// result shows on the output ports for one cycle with valid_o high; the
// receiver cannot stall. The rotation clears the hit valid flags.
// Reset empties the map and the sync store and clears the reference
// state and event information.
module tdc_hit_time_channel_mapper_top #(
  parameter int MAP_DEPTH  = 64,
  parameter int SYNC_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic [31:0]        serial_i,
  input  logic [4:0]         slot_i,
  input  logic [6:0]         channel_i,
  input  logic [31:0]        tdc_value_i,
  input  logic               is_leading_i,
  input  logic [1:0]         plane_i,
  input  logic [7:0]         strip_i,
  input  logic [7:0]         side_i,
  input  logic [31:0]        event_number_i,
  input  logic [31:0]        sync_sec_i,
  input  logic [29:0]        time_ns_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic [1:0]         out_plane_o,
  output logic [7:0]         out_strip_o,
  output logic [7:0]         out_side_o,
  output logic signed [47:0] lead_time_o,
  output logic signed [47:0] trail_time_o,
  output logic [31:0]        event_id_o,
  output logic [31:0]        event_sec_o,
  output logic [29:0]        event_ns_o,
  output logic               last_o
);

  localparam int MapCntW  = $clog2(MAP_DEPTH + 1);
  localparam int SyncCntW = $clog2(SYNC_DEPTH + 1);
  localparam int RotW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_WRITE, ST_EMIT, ST_FLUSH} state_e;

  state_e state_q;

  logic [2:0]  mode_q;
  logic [31:0] serial_q, value_q, ev_num_q, ev_sec_in_q;
  logic [4:0]  slot_q;
  logic [6:0]  channel_q;
  logic        lead_q;
  logic [1:0]  plane_q;
  logic [7:0]  strip_q, side_q;
  logic [29:0] ns_q;

  logic [MapCntW-1:0]  map_count_q;
  logic [SyncCntW-1:0] sync_count_q;
  logic [33:0]         ref_time_q;
  logic [31:0]         ref_serial_q;
  logic                ref_found_q;
  logic [29:0]         ref_sync_q, hit_sync_q;
  logic [31:0]         ev_id_q, ev_sec_q;
  logic [29:0]         ev_ns_q;
  logic signed [47:0]  part_q;
  logic [RotW-1:0]     rot_q;

  logic                pend_q;
  tdcm_pkg::map_cell_t pend_cell_q;

  logic                r_hit_q, r_last_q, r_valid_q;
  logic [1:0]          r_plane_q;
  logic [7:0]          r_strip_q, r_side_q;
  logic [47:0]         r_lead_q, r_trail_q;

  tdcm_pkg::cell_ctrl_t ctrl;
  tdcm_pkg::map_entry_t new_entry;
  tdcm_pkg::map_cell_t  cell_data [MAP_DEPTH];
  tdcm_pkg::map_cell_t  head;
  logic [MAP_DEPTH-1:0] match, first_sel, cell_sel, taken;
  logic [29:0]          sync_chain [SYNC_DEPTH+1];
  logic [33:0]          v3;
  logic signed [30:0]   sync_diff;
  logic signed [47:0]   tm;
  logic                 head_hit;

  assign busy      = (state_q != ST_IDLE);
  assign new_entry = '{serial: serial_q, slot: slot_q, channel: channel_q,
                       plane: plane_q, strip: strip_q, side: side_q};
  assign v3        = {2'b00, value_q} + {1'b0, value_q, 1'b0};
  assign sync_diff = $signed({1'b0, ref_sync_q}) - $signed({1'b0, hit_sync_q});
  assign tm        = part_q - ({{17{sync_diff[30]}}, sync_diff} <<< 7);
  assign head      = cell_data[0];
  assign head_hit  = head.used && (head.lead_vld || head.trail_vld);

  always_comb begin
    ctrl.load    = (state_q == ST_EXEC) && (mode_q == tdcm_pkg::MODE_MAP) &&
                   (map_count_q < MapCntW'(MAP_DEPTH));
    ctrl.shift   = (state_q == ST_EMIT);
    ctrl.wr      = (state_q == ST_WRITE);
    ctrl.wr_lead = lead_q;
    ctrl.wr_time = tm;
  end

  assign taken[0] = 1'b0;
  for (genvar k = 0; k < MAP_DEPTH; k++) begin : g_map
    tdcm_pkg::map_cell_t shift_in;
    always_comb begin
      shift_in = cell_data[(k + 1) % MAP_DEPTH];
      if (k == MAP_DEPTH - 1) begin
        shift_in.lead_vld  = 1'b0;
        shift_in.trail_vld = 1'b0;
      end
    end
    if (k < MAP_DEPTH - 1) begin : g_take
      assign taken[k+1] = taken[k] | match[k];
    end
    assign first_sel[k] = match[k] & ~taken[k];
    assign cell_sel[k]  = ctrl.load ? (map_count_q == MapCntW'(k)) : first_sel[k];

    tdcm_map_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .sel_i         (cell_sel[k]),
      .entry_i       (new_entry),
      .shift_data_i  (shift_in),
      .key_serial_i  (serial_q),
      .key_slot_i    (slot_q),
      .key_channel_i (channel_q),
      .match_o       (match[k]),
      .data_o        (cell_data[k])
    );
  end

  assign sync_chain[0] = hit_sync_q;
  for (genvar s = 0; s < SYNC_DEPTH; s++) begin : g_sync
    tdcm_sync_cell u_sync (
      .clk_i        (clk_i),
      .load_i       ((state_q == ST_EXEC) && (mode_q == tdcm_pkg::MODE_SYNC) &&
                     (sync_count_q == SyncCntW'(s))),
      .used_i       (sync_count_q > SyncCntW'(s)),
      .serial_i     (serial_q),
      .ns_i         (ns_q),
      .key_serial_i (serial_q),
      .ns_in_i      (sync_chain[s]),
      .ns_o         (sync_chain[s+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= '0;
      serial_q     <= '0;
      value_q      <= '0;
      ev_num_q     <= '0;
      ev_sec_in_q  <= '0;
      slot_q       <= '0;
      channel_q    <= '0;
      lead_q       <= 1'b0;
      plane_q      <= '0;
      strip_q      <= '0;
      side_q       <= '0;
      ns_q         <= '0;
      map_count_q  <= '0;
      sync_count_q <= '0;
      ref_time_q   <= '0;
      ref_serial_q <= '0;
      ref_found_q  <= 1'b0;
      ref_sync_q   <= '0;
      hit_sync_q   <= '0;
      ev_id_q      <= '0;
      ev_sec_q     <= '0;
      ev_ns_q      <= '0;
      part_q       <= '0;
      rot_q        <= '0;
      pend_q       <= 1'b0;
      pend_cell_q  <= '0;
      r_valid_q    <= 1'b0;
      r_hit_q      <= 1'b0;
      r_last_q     <= 1'b0;
      r_plane_q    <= '0;
      r_strip_q    <= '0;
      r_side_q     <= '0;
      r_lead_q     <= '0;
      r_trail_q    <= '0;
    end else begin
      r_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            mode_q      <= mode_i;
            serial_q    <= serial_i;
            value_q     <= tdc_value_i;
            ev_num_q    <= event_number_i;
            ev_sec_in_q <= sync_sec_i;
            slot_q      <= slot_i;
            channel_q   <= channel_i;
            lead_q      <= is_leading_i;
            plane_q     <= plane_i;
            strip_q     <= strip_i;
            side_q      <= side_i;
            ns_q        <= time_ns_i;
            state_q     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          case (mode_q)
            tdcm_pkg::MODE_MAP: begin
              if (ctrl.load) begin
                map_count_q <= map_count_q + 1'b1;
              end
            end
            tdcm_pkg::MODE_REF: begin
              if (lead_q && !ref_found_q) begin
                ref_time_q   <= v3;
                ref_serial_q <= serial_q;
                ref_found_q  <= 1'b1;
              end
            end
            tdcm_pkg::MODE_SYNC: begin
              if (serial_q == ref_serial_q) begin
                ref_sync_q <= ns_q;
                ev_id_q    <= ev_num_q;
                ev_sec_q   <= ev_sec_in_q;
                ev_ns_q    <= ns_q;
              end
              if (sync_count_q < SyncCntW'(SYNC_DEPTH)) begin
                sync_count_q <= sync_count_q + 1'b1;
              end
            end
            tdcm_pkg::MODE_HIT: begin
              hit_sync_q <= sync_chain[SYNC_DEPTH];
              part_q     <= $signed({14'd0, v3}) - $signed({14'd0, ref_time_q});
              state_q    <= ST_WRITE;
            end
            tdcm_pkg::MODE_END: begin
              rot_q   <= '0;
              pend_q  <= 1'b0;
              state_q <= ST_EMIT;
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_WRITE: begin
          state_q <= ST_IDLE;
        end
        ST_EMIT: begin
          if (head_hit) begin
            pend_q      <= 1'b1;
            pend_cell_q <= head;
            if (pend_q) begin
              r_valid_q <= 1'b1;
              r_hit_q   <= 1'b1;
              r_last_q  <= 1'b0;
              r_plane_q <= pend_cell_q.entry.plane;
              r_strip_q <= pend_cell_q.entry.strip;
              r_side_q  <= pend_cell_q.entry.side;
              r_lead_q  <= pend_cell_q.lead_vld ? pend_cell_q.lead_time : '0;
              r_trail_q <= pend_cell_q.trail_vld ? pend_cell_q.trail_time : '0;
            end
          end
          rot_q <= rot_q + 1'b1;
          if (rot_q == RotW'(MAP_DEPTH - 1)) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          r_valid_q    <= 1'b1;
          r_last_q     <= 1'b1;
          r_hit_q      <= pend_q;
          r_plane_q    <= pend_q ? pend_cell_q.entry.plane : '0;
          r_strip_q    <= pend_q ? pend_cell_q.entry.strip : '0;
          r_side_q     <= pend_q ? pend_cell_q.entry.side : '0;
          r_lead_q     <= (pend_q && pend_cell_q.lead_vld) ? pend_cell_q.lead_time : '0;
          r_trail_q    <= (pend_q && pend_cell_q.trail_vld) ? pend_cell_q.trail_time : '0;
          pend_q       <= 1'b0;
          sync_count_q <= '0;
          ref_found_q  <= 1'b0;
          ref_serial_q <= '0;
          ref_sync_q   <= '0;
          hit_sync_q   <= '0;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign valid_o      = r_valid_q;
  assign hit_o        = r_hit_q;
  assign last_o       = r_last_q;
  assign out_plane_o  = r_plane_q;
  assign out_strip_o  = r_strip_q;
  assign out_side_o   = r_side_q;
  assign lead_time_o  = $signed(r_lead_q);
  assign trail_time_o = $signed(r_trail_q);
  assign event_id_o   = ev_id_q;
  assign event_sec_o  = ev_sec_q;
  assign event_ns_o   = ev_ns_q;

endmodule
